### rtl/core/tagrec_pkg.sv
// Shared types, codes and defaults of the tagged record decoder.
`default_nettype none

package tagrec_pkg;

  // Default sizing of the block.
  localparam int unsigned MaxColumnsDefault = 16;
  localparam int unsigned QueueDepthDefault = 4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COLUMN_COUNT  = 2'd0;
  localparam logic [1:0] CFG_COLUMN_TYPES  = 2'd1;
  localparam logic [1:0] CFG_NULLABLE_MASK = 2'd2;

  // Column type codes, which are also the tag byte values.
  localparam logic [1:0] TYPE_NULL    = 2'd0;
  localparam logic [1:0] TYPE_INTEGER = 2'd1;
  localparam logic [1:0] TYPE_BOOLEAN = 2'd2;
  localparam logic [1:0] TYPE_TEXT    = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_NULL = 3'd0;
  localparam logic [2:0] KIND_INT  = 3'd1;
  localparam logic [2:0] KIND_BOOL = 3'd2;
  localparam logic [2:0] KIND_HDR  = 3'd3;
  localparam logic [2:0] KIND_BYTE = 3'd4;
  localparam logic [2:0] KIND_ERR  = 3'd5;

  // Error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TRUNCATED = 3'd1;
  localparam logic [2:0] ERR_BAD_NULL  = 3'd2;
  localparam logic [2:0] ERR_MISMATCH  = 3'd3;
  localparam logic [2:0] ERR_BAD_BOOL  = 3'd4;
  localparam logic [2:0] ERR_TRAILING  = 3'd5;
  localparam logic [2:0] ERR_NULL_TYPE = 3'd6;

  // One decoded result item.
  typedef struct packed {
    logic [3:0]  column;
    logic [2:0]  kind;
    logic [63:0] payload;
    logic [2:0]  error_code;
    logic        record_done;
  } tagrec_result_t;

endpackage

`default_nettype wire

### rtl/core/tagged_record_decoder_top.sv
// Each result item passes through the result queue and then the output register.
// Throughput: one record byte per cycle while the queue has room, set by the front end.
// The result queue lets the front keep taking bytes while the consumer stalls briefly.
// Reset clears the decode state, the queue and the output; registers return to one column,
// all types null and nothing nullable. No clearing pass is needed after reset.
`default_nettype none

module tagged_record_decoder_top import tagrec_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = MaxColumnsDefault,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         record_byte_i,
  input  wire logic               end_of_record_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [3:0]              column_o,
  output logic [2:0]              kind_o,
  output logic signed [63:0]      payload_o,
  output logic [2:0]              error_code_o,
  output logic                    record_done_o
);

  logic           push;
  logic           q_full;
  logic           q_empty;
  logic           pop;
  tagrec_result_t front_res;
  tagrec_result_t q_res;
  tagrec_result_t out_res;

  // Byte decoder.
  tagrec_front #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .record_byte_i   (record_byte_i),
    .end_of_record_i (end_of_record_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .result_o        (front_res)
  );

  // Result queue.
  tagrec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_res),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (q_res)
  );

  // Output stage.
  tagrec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_res),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign column_o      = out_res.column;
  assign kind_o        = out_res.kind;
  assign payload_o     = out_res.payload;
  assign error_code_o  = out_res.error_code;
  assign record_done_o = out_res.record_done;

endmodule

`default_nettype wire

### rtl/core/tagrec_front.sv
// Front end: accepts record bytes, tracks the decode state and classifies each byte.
`default_nettype none

module tagrec_front import tagrec_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = MaxColumnsDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_idx_i,
  input  wire logic [31:0]    cfg_wdata_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [7:0]     record_byte_i,
  input  wire logic           end_of_record_i,
  input  wire logic           q_full_i,
  output logic                push_o,
  output tagrec_result_t      result_o
);

  // Decode phases.
  localparam logic [2:0] PhTag  = 3'd0;
  localparam logic [2:0] PhInt  = 3'd1;
  localparam logic [2:0] PhBool = 3'd2;
  localparam logic [2:0] PhLen  = 3'd3;
  localparam logic [2:0] PhText = 3'd4;

  localparam logic [4:0] MaxCnt = 5'(MAX_COLUMNS);

  // Configuration registers.
  logic [4:0]  col_count_q;
  logic [31:0] col_types_q;
  logic [15:0] nullable_q;

  // Decode state.
  logic [4:0]  col_q, col_d;
  logic [2:0]  phase_q, phase_d;
  logic [2:0]  bcnt_q, bcnt_d;
  logic [63:0] asm_q, asm_d;
  logic [31:0] rem_q, rem_d;
  logic        disc_q, disc_d;

  logic        accept;
  logic [4:0]  eff_cnt;
  logic [1:0]  cur_type;
  logic        adv;
  logic        hit;
  logic        clr;
  logic [2:0]  kind;
  logic [2:0]  err;
  logic [63:0] pay;
  logic [4:0]  rcol;
  logic [31:0] len;

  function automatic logic [1:0] type_of(logic [31:0] types, logic [3:0] c);
    return types[{c, 1'b0} +: 2];
  endfunction

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= 5'd1;
      col_types_q <= '0;
      nullable_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLUMN_COUNT:  col_count_q <= cfg_wdata_i[4:0];
        CFG_COLUMN_TYPES:  col_types_q <= cfg_wdata_i;
        CFG_NULLABLE_MASK: nullable_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Column count in use: zero counts as one, and it is capped at the maximum.
  always_comb begin
    if (col_count_q == 5'd0) begin
      eff_cnt = 5'd1;
    end else if (col_count_q > MaxCnt) begin
      eff_cnt = MaxCnt;
    end else begin
      eff_cnt = col_count_q;
    end
  end

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !q_full_i;
  assign len        = {record_byte_i, asm_q[23:0]};

  // Per-byte decode step.
  always_comb begin
    col_d    = col_q;
    phase_d  = phase_q;
    bcnt_d   = bcnt_q;
    asm_d    = asm_q;
    rem_d    = rem_q;
    disc_d   = disc_q;
    adv      = 1'b0;
    hit      = 1'b0;
    clr      = 1'b0;
    kind     = KIND_NULL;
    err      = ERR_NONE;
    pay      = '0;
    rcol     = col_q;
    cur_type = type_of(col_types_q, col_q[3:0]);

    if (disc_q) begin
      // Dropping the rest of a failed record.
      clr = end_of_record_i;
    end else begin
      unique case (phase_q)
        PhTag: begin
          if (col_q >= eff_cnt) begin
            err  = ERR_TRAILING;
            rcol = eff_cnt - 5'd1;
          end else if (cur_type == TYPE_NULL) begin
            err = ERR_NULL_TYPE;
          end else if (record_byte_i == 8'd0) begin
            if (!nullable_q[col_q[3:0]]) begin
              err = ERR_BAD_NULL;
            end else begin
              hit  = 1'b1;
              kind = KIND_NULL;
              adv  = 1'b1;
            end
          end else if (record_byte_i != {6'd0, cur_type}) begin
            err = ERR_MISMATCH;
          end else begin
            bcnt_d = '0;
            asm_d  = '0;
            if (cur_type == TYPE_INTEGER) begin
              phase_d = PhInt;
            end else if (cur_type == TYPE_BOOLEAN) begin
              phase_d = PhBool;
            end else begin
              phase_d = PhLen;
            end
          end
        end
        PhInt: begin
          asm_d[{bcnt_q, 3'b000} +: 8] = record_byte_i;
          if (bcnt_q == 3'd7) begin
            hit  = 1'b1;
            kind = KIND_INT;
            pay  = {record_byte_i, asm_q[55:0]};
            adv  = 1'b1;
          end else begin
            bcnt_d = bcnt_q + 3'd1;
          end
        end
        PhBool: begin
          if (record_byte_i > 8'd1) begin
            err = ERR_BAD_BOOL;
          end else begin
            hit  = 1'b1;
            kind = KIND_BOOL;
            pay  = {56'd0, record_byte_i};
            adv  = 1'b1;
          end
        end
        PhLen: begin
          if (bcnt_q == 3'd3) begin
            hit  = 1'b1;
            kind = KIND_HDR;
            pay  = {32'd0, len};
            if (len == 32'd0) begin
              adv = 1'b1;
            end else begin
              phase_d = PhText;
              rem_d   = len;
              bcnt_d  = '0;
              asm_d   = '0;
            end
          end else begin
            asm_d[{bcnt_q, 3'b000} +: 8] = record_byte_i;
            bcnt_d = bcnt_q + 3'd1;
          end
        end
        default: begin
          // Text body bytes.
          hit   = 1'b1;
          kind  = KIND_BYTE;
          pay   = {56'd0, record_byte_i};
          rem_d = rem_q - 32'd1;
          if (rem_q == 32'd1) begin
            adv = 1'b1;
          end
        end
      endcase

      // Move on to the next column.
      if (adv) begin
        col_d   = col_q + 5'd1;
        phase_d = PhTag;
        bcnt_d  = '0;
        asm_d   = '0;
        rem_d   = '0;
      end

      // A record that ends before all columns are complete.
      if (err == ERR_NONE && end_of_record_i &&
          !(phase_d == PhTag && col_d >= eff_cnt)) begin
        rcol = col_d;
        if (phase_d == PhTag && type_of(col_types_q, col_d[3:0]) == TYPE_NULL) begin
          err = ERR_NULL_TYPE;
        end else if (phase_d == PhBool) begin
          err = ERR_BAD_BOOL;
        end else begin
          err = ERR_TRUNCATED;
        end
      end

      if (err != ERR_NONE) begin
        hit  = 1'b1;
        kind = KIND_ERR;
        pay  = '0;
        if (end_of_record_i) begin
          clr = 1'b1;
        end else begin
          disc_d = 1'b1;
        end
      end else if (hit && end_of_record_i) begin
        clr = 1'b1;
      end
    end

    // Start afresh for the next record.
    if (clr) begin
      col_d   = '0;
      phase_d = PhTag;
      bcnt_d  = '0;
      asm_d   = '0;
      rem_d   = '0;
      disc_d  = 1'b0;
    end
  end

  // State registers, updated on each accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      phase_q <= PhTag;
      bcnt_q  <= '0;
      asm_q   <= '0;
      rem_q   <= '0;
      disc_q  <= 1'b0;
    end else if (accept) begin
      col_q   <= col_d;
      phase_q <= phase_d;
      bcnt_q  <= bcnt_d;
      asm_q   <= asm_d;
      rem_q   <= rem_d;
      disc_q  <= disc_d;
    end
  end

  // Result towards the queue.
  assign push_o                 = accept && hit;
  assign result_o.column        = rcol[3:0];
  assign result_o.kind          = kind;
  assign result_o.payload       = pay;
  assign result_o.error_code    = err;
  assign result_o.record_done   = end_of_record_i;

  // The column index never runs past the largest schema.
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= MaxCnt)
    else $error("column index beyond the maximum column count");

  // Nothing is produced while the rest of a failed record is being dropped.
  a_discard_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && disc_q |-> !push_o)
    else $error("result produced while discarding");

  // An error on a byte that is not the last one starts discarding.
  a_err_discard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && result_o.kind == KIND_ERR && !end_of_record_i |=> disc_q)
    else $error("error mid-record did not start discarding");

endmodule

`default_nettype wire

### rtl/core/tagrec_queue.sv
// Short result queue between the front end and the output stage.
`default_nettype none

module tagrec_queue import tagrec_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tagrec_result_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output tagrec_result_t      data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  tagrec_result_t        mem_q [DEPTH];
  logic [PtrW-1:0]       wr_q, rd_q;
  logic [CntW-1:0]       cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // The front end never offers an item to a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("item pushed into a full queue");

  // The fill count stays within the depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue fill count beyond depth");

endmodule

`default_nettype wire

### rtl/core/tagrec_back.sv
// Back end: output register that hands result items to the consumer.
`default_nettype none

module tagrec_back import tagrec_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_empty_i,
  input  wire tagrec_result_t q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output tagrec_result_t      out_data_o
);

  logic           valid_q;
  tagrec_result_t data_q;
  logic           load;

  // Take the next item whenever the output register is free or being emptied.
  assign load  = !q_empty_i && (!valid_q || out_ready_i);
  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= q_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire
